### hdl/bsoc_pkg.sv
// shared types and constants of the battery state-of-charge blend estimator
// no dependencies; imported by battery_soc_blend_estimator_top
`timescale 1ns / 1ps
`default_nettype none

package bsoc_pkg;

    // field widths
    localparam int C_SOC_W    = 14;
    localparam int C_MV_W     = 13;
    localparam int C_CUR_W    = 16;
    localparam int C_IVL_W    = 16;
    localparam int C_CAP_W    = 16;
    localparam int C_LOW_W    = 15;
    localparam int C_CFG_W    = 16;
    localparam int C_IN_W     = 64;
    localparam int C_OUT_W    = 16;

    // coulomb path
    localparam int C_PROD_W   = 31;   // |current| * interval
    localparam int C_DIV_W    = 25;   // 360 * capacity
    localparam int C_Q_W      = 15;   // quotient, saturated
    localparam int C_CMP_W    = C_PROD_W + C_Q_W - 6;
    localparam logic [C_SOC_W-1:0] C_SOC_FULL = 14'd10000;

    // voltage curve
    localparam int C_SEGS = 10;
    localparam logic [C_MV_W-1:0] C_CURVE_MV [11] = '{
        13'd4200, 13'd4100, 13'd4000, 13'd3900, 13'd3800, 13'd3750,
        13'd3700, 13'd3650, 13'd3550, 13'd3450, 13'd3300
    };

    // reciprocal multipliers for exact floor division of small values
    localparam logic [15:0] C_RECIP3 = 16'd43691;   // 2^17 / 3, rounded up
    localparam logic [15:0] C_RECIP5 = 16'd52429;   // 2^18 / 5, rounded up

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_CAPACITY    = 1'b0,
        REG_LOW_CURRENT = 1'b1
    } t_cfg_reg;

    localparam logic [C_DIV_W-1:0] C_DIV_RESET = 25'd720000;  // 360 * 2000
    localparam logic [C_LOW_W-1:0] C_LOW_RESET = 15'd50;

    // soc at the lower end of a segment
    function automatic logic [C_SOC_W-1:0] seg_base(input logic [3:0] seg);
        logic [C_SOC_W-1:0] base;
        unique case (seg)
            4'd0:    base = 14'd9000;
            4'd1:    base = 14'd8000;
            4'd2:    base = 14'd7000;
            4'd3:    base = 14'd6000;
            4'd4:    base = 14'd5000;
            4'd5:    base = 14'd4000;
            4'd6:    base = 14'd3000;
            4'd7:    base = 14'd2000;
            4'd8:    base = 14'd1000;
            default: base = 14'd0;
        endcase
        return base;
    endfunction

    // 1000 / segment width, as integer multiplier (x20 then /3 for 150 mV)
    function automatic logic [4:0] seg_mul(input logic [3:0] seg);
        logic [4:0] m;
        unique case (seg)
            4'd4, 4'd5, 4'd6, 4'd9: m = 5'd20;
            default:                m = 5'd10;
        endcase
        return m;
    endfunction

    function automatic logic seg_div3(input logic [3:0] seg);
        return seg == 4'd9;
    endfunction

    // stage after input decode
    typedef struct packed {
        logic [C_SOC_W-1:0] soc;
        logic               neg;
        logic               low;
        logic [C_CUR_W-1:0] mag;
        logic [C_IVL_W-1:0] interval;
        logic               vfull;
        logic               vzero;
        logic [3:0]         seg;
        logic [7:0]         dv;
    } t_s1;

    // stage after the multiplies
    typedef struct packed {
        logic [C_SOC_W-1:0]  soc;
        logic                neg;
        logic                low;
        logic [C_PROD_W-1:0] prod;
        logic                vfull;
        logic                vzero;
        logic [3:0]          seg;
        logic [11:0]         vx;
    } t_s2;

    // divider stage
    typedef struct packed {
        logic [C_SOC_W-1:0]  soc;
        logic                neg;
        logic                low;
        logic [C_SOC_W-1:0]  vsoc;
        logic                sat;
        logic [C_PROD_W-1:0] rem;
        logic [C_Q_W-1:0]    q;
    } t_div;

    // stage after coulomb clamp
    typedef struct packed {
        logic               low;
        logic [C_SOC_W-1:0] cc;
        logic [C_SOC_W-1:0] vsoc;
    } t_cc;

endpackage

`default_nettype wire

### hdl/battery_soc_blend_estimator_top.sv
// battery state-of-charge blend estimator: coulomb count, voltage curve, blend
// depends on bsoc_pkg
`timescale 1ns / 1ps
`default_nettype none

// datapath order: stage 1, stage 2, divider entry, divider, coulomb clamp, blend, output register
// throughput: one word per cycle while not stalled (see below); the divider is a 15-stage restoring pipeline
// that forms |current * interval| / (360 * capacity), one quotient bit per stage
// stall: the pipeline freezes while the two-entry output buffer is full
// reset (synchronous, active low): clears all valid bits, capacity 2000, threshold 50

module battery_soc_blend_estimator_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // input stream
    input  wire logic                         i_s_axis_tvalid,
    output      logic                         o_s_axis_tready,
    // [13:0] soc_before, [26:14] voltage_mv, [42:27] current_ma,
    // [58:43] interval_ms, [63:59] zero
    input  wire logic [bsoc_pkg::C_IN_W-1:0]  i_s_axis_tdata,
    // output stream
    output      logic                         o_m_axis_tvalid,
    input  wire logic                         i_m_axis_tready,
    // [13:0] soc_after, [15:14] zero
    output      logic [bsoc_pkg::C_OUT_W-1:0] o_m_axis_tdata,
    // configuration writes
    input  wire logic                         i_cfg_wr_en,
    input  wire logic                         i_cfg_addr,
    input  wire logic [bsoc_pkg::C_CFG_W-1:0] i_cfg_wr_data
);
    import bsoc_pkg::*;

    // ---------------------------------------------------------------
    // configuration: divisor is kept premultiplied by 360
    // ---------------------------------------------------------------
    logic [C_DIV_W-1:0] r_div;
    logic [C_LOW_W-1:0] r_low;
    logic [C_CAP_W-1:0] w_cap;

    // zero capacity acts as one
    assign w_cap = (i_cfg_wr_data == '0) ? C_CAP_W'(1) : i_cfg_wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div <= C_DIV_RESET;
            r_low <= C_LOW_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                REG_CAPACITY:    r_div <= C_DIV_W'(w_cap) * C_DIV_W'(360);
                REG_LOW_CURRENT: r_low <= i_cfg_wr_data[C_LOW_W-1:0];
                default:         r_div <= r_div;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // pipeline advance: held only when the output skid entry is occupied
    // ---------------------------------------------------------------
    logic r_skid_v;
    logic w_en;
    logic w_accept;

    assign w_en            = !r_skid_v;
    // no word is taken while reset is held
    assign o_s_axis_tready = w_en && i_rst_n;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // ---------------------------------------------------------------
    // stage 1: unpack, current magnitude, threshold compare, curve segment
    // ---------------------------------------------------------------
    logic               r_s1_v;
    t_s1                r_s1;
    t_s1                n_s1;
    logic [C_MV_W-1:0]  w_mv;
    logic [C_CUR_W-1:0] w_cur;

    assign w_mv  = i_s_axis_tdata[26:14];
    assign w_cur = i_s_axis_tdata[42:27];

    always_comb begin
        n_s1          = '0;
        n_s1.soc      = i_s_axis_tdata[13:0];
        n_s1.interval = i_s_axis_tdata[58:43];
        n_s1.neg      = w_cur[C_CUR_W-1];
        // -32768 maps to 32768, which still fits unsigned
        n_s1.mag      = n_s1.neg ? C_CUR_W'(~w_cur + 1'b1) : w_cur;
        n_s1.low      = n_s1.mag < {1'b0, r_low};
        n_s1.vfull    = w_mv >= C_CURVE_MV[0];
        n_s1.vzero    = w_mv <= C_CURVE_MV[C_SEGS];
        // segments are disjoint, at most one matches
        for (int i = 0; i < C_SEGS; i++) begin
            if (w_mv <= C_CURVE_MV[i] && w_mv > C_CURVE_MV[i+1]) begin
                n_s1.seg = 4'(i);
                n_s1.dv  = 8'(w_mv - C_CURVE_MV[i+1]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_en) begin
            r_s1_v <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1 <= n_s1;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: charge product and scaled curve offset
    // ---------------------------------------------------------------
    logic r_s2_v;
    t_s2  r_s2;
    t_s2  n_s2;

    always_comb begin
        n_s2.soc   = r_s1.soc;
        n_s2.neg   = r_s1.neg;
        n_s2.low   = r_s1.low;
        // max 32768 * 65535 stays below 2^31
        n_s2.prod  = C_PROD_W'(32'(r_s1.mag) * 32'(r_s1.interval));
        n_s2.vfull = r_s1.vfull;
        n_s2.vzero = r_s1.vzero;
        n_s2.seg   = r_s1.seg;
        n_s2.vx    = 12'(13'(r_s1.dv) * 13'(seg_mul(r_s1.seg)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_en) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2 <= n_s2;
        end
    end

    // ---------------------------------------------------------------
    // stage 3 (divider entry): voltage soc, quotient overflow check
    // ---------------------------------------------------------------
    localparam int C_DSTG = C_Q_W + 1;

    logic [C_DSTG-1:0] r_dv_v;
    t_div              r_dv [C_DSTG];
    t_div              n_dv0;
    logic [27:0]       w_div3;
    logic [9:0]        w_vinc;
    logic [C_CMP_W-1:0] w_top;

    assign w_div3 = 28'(r_s2.vx) * 28'(C_RECIP3);
    assign w_vinc = seg_div3(r_s2.seg) ? w_div3[26:17] : r_s2.vx[9:0];
    assign w_top  = C_CMP_W'(r_div) << C_Q_W;

    always_comb begin
        n_dv0.soc  = r_s2.soc;
        n_dv0.neg  = r_s2.neg;
        n_dv0.low  = r_s2.low;
        if (r_s2.vfull) begin
            n_dv0.vsoc = C_SOC_FULL;
        end else if (r_s2.vzero) begin
            n_dv0.vsoc = '0;
        end else begin
            n_dv0.vsoc = seg_base(r_s2.seg) + C_SOC_W'(w_vinc);
        end
        // a quotient past 15 bits drives cc to a rail either way
        n_dv0.sat  = C_CMP_W'(r_s2.prod) >= w_top;
        n_dv0.rem  = r_s2.prod;
        n_dv0.q    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v <= '0;
        end else if (w_en) begin
            r_dv_v <= {r_dv_v[C_DSTG-2:0], r_s2_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv[0] <= n_dv0;
        end
    end

    // ---------------------------------------------------------------
    // restoring divider, one quotient bit per stage, msb first
    // ---------------------------------------------------------------
    for (genvar k = 1; k < C_DSTG; k++) begin : g_div
        localparam int J = C_Q_W - k;
        logic [C_CMP_W-1:0] w_shd;
        logic [C_CMP_W-1:0] w_rem;
        logic               w_ge;
        t_div               n_dv;

        assign w_shd = C_CMP_W'(r_div) << J;
        assign w_rem = C_CMP_W'(r_dv[k-1].rem);
        assign w_ge  = w_rem >= w_shd;

        always_comb begin
            n_dv      = r_dv[k-1];
            n_dv.rem  = w_ge ? C_PROD_W'(w_rem - w_shd) : r_dv[k-1].rem;
            n_dv.q[J] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv[k] <= n_dv;
            end
        end
    end

    // ---------------------------------------------------------------
    // coulomb soc: apply signed delta, clamp to 0..10000
    // ---------------------------------------------------------------
    logic               r_cc_v;
    t_cc                r_cc;
    t_cc                n_cc;
    logic [C_Q_W-1:0]   w_delta;
    logic signed [16:0] w_sum;

    assign w_delta = r_dv[C_DSTG-1].sat ? '1 : r_dv[C_DSTG-1].q;

    always_comb begin
        // discharge subtracts, charge adds
        if (r_dv[C_DSTG-1].neg) begin
            w_sum = $signed({3'b000, r_dv[C_DSTG-1].soc}) + $signed({2'b00, w_delta});
        end else begin
            w_sum = $signed({3'b000, r_dv[C_DSTG-1].soc}) - $signed({2'b00, w_delta});
        end
        n_cc.low  = r_dv[C_DSTG-1].low;
        n_cc.vsoc = r_dv[C_DSTG-1].vsoc;
        if (w_sum < 0) begin
            n_cc.cc = '0;
        end else if (w_sum > $signed({3'b000, C_SOC_FULL})) begin
            n_cc.cc = C_SOC_FULL;
        end else begin
            n_cc.cc = w_sum[C_SOC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc_v <= 1'b0;
        end else if (w_en) begin
            r_cc_v <= r_dv_v[C_DSTG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cc <= n_cc;
        end
    end

    // ---------------------------------------------------------------
    // blend: 20/80 or 80/20 as (a + 4b) / 5, divide by reciprocal multiply
    // ---------------------------------------------------------------
    logic        r_mul_v;
    logic [31:0] r_mul;
    logic [15:0] w_mix;

    // at most 50000, never past 10000 after the divide
    assign w_mix = r_cc.low ? 16'(r_cc.cc) + {r_cc.vsoc, 2'b00}
                            : {r_cc.cc, 2'b00} + 16'(r_cc.vsoc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_v <= 1'b0;
        end else if (w_en) begin
            r_mul_v <= r_cc_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mul <= 32'(w_mix) * 32'(C_RECIP5);
        end
    end

    // ---------------------------------------------------------------
    // output register plus skid entry
    // ---------------------------------------------------------------
    logic               r_out_v;
    logic [C_SOC_W-1:0] r_out_data;
    logic [C_SOC_W-1:0] r_skid_data;
    logic               w_take;
    logic               w_new_v;
    logic [C_SOC_W-1:0] w_new;

    assign w_take  = r_out_v && i_m_axis_tready;
    assign w_new_v = r_mul_v && w_en;
    assign w_new   = r_mul[31:18];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            priority if (r_skid_v) begin
                if (w_take) begin
                    r_out_data <= r_skid_data;
                    r_skid_v   <= 1'b0;
                end
            end else if (w_new_v) begin
                if (!r_out_v || w_take) begin
                    r_out_v    <= 1'b1;
                    r_out_data <= w_new;
                end else begin
                    r_skid_v    <= 1'b1;
                    r_skid_data <= w_new;
                end
            end else if (w_take) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = C_OUT_W'(r_out_data);

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held while output register empty");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[C_SOC_W-1:0] <= C_SOC_FULL))
        else $error("soc_after above full scale");

    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !i_m_axis_tready) |=> ($stable(r_skid_data) && r_skid_v))
        else $error("skid word changed while stalled");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !i_m_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted while output buffer full");

    a_vsoc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_v[0] |-> (r_dv[0].vsoc <= C_SOC_FULL))
        else $error("voltage soc above full scale");

endmodule

`default_nettype wire
